// ===== design/isgpl_pkg.sv =====
// Shared types and constants of the I/Q soft-gain peak limiter.
package isgpl_pkg;

   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned GAIN_W   = 16;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd4096;
   localparam logic [GAIN_W-1:0] LIMIT_RESET = 16'd0;

   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_GAIN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_AGC_LIMIT    = 1'b1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] in_i;
      logic signed [SAMPLE_W-1:0] in_q;
      logic                       end_of_block;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_i;
      logic signed [SAMPLE_W-1:0] out_q;
      logic                       gain_cut;
      logic                       end_of_block_out;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      MUL_XI_GAIN,
      MUL_XQ_GAIN,
      MUL_SQUARE,
      MUL_LIMIT_GAIN
   } mul_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_I,
      ST_SQ_I,
      ST_MUL_Q,
      ST_SQ_Q,
      ST_SUM,
      ST_ROOT_INIT,
      ST_ROOT,
      ST_CHECK,
      ST_DIV_INIT,
      ST_DIV,
      ST_GAIN,
      ST_OUT_I,
      ST_OUT_I2,
      ST_OUT_Q2,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        req_load;
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        acc_add;
      logic        root_init;
      logic        root_step;
      logic        cut_eval;
      logic        div_init;
      logic        div_step;
      logic        gain_load;
      logic        out_i_load;
      logic        out_q_load;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic              root_last;
      logic              cut;
      logic [GAIN_W-1:0] gain;
   } status_type;

endpackage

// ===== design/isgpl_stream_if.sv =====
// Valid/ready stream channel carrying one payload per transaction.
interface isgpl_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/isgpl_ctrl.sv =====
// Controller state machine sequencing the limiter datapath.
module isgpl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   input  isgpl_pkg::status_type stat,
   output isgpl_pkg::cmd_type    cmd
);
   import isgpl_pkg::*;

   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_MUL_I;
         ST_MUL_I:     state_in = ST_SQ_I;
         ST_SQ_I:      state_in = ST_MUL_Q;
         ST_MUL_Q:     state_in = ST_SQ_Q;
         ST_SQ_Q:      state_in = ST_SUM;
         ST_SUM:       state_in = ST_ROOT_INIT;
         ST_ROOT_INIT: state_in = ST_ROOT;
         ST_ROOT:      if (stat.root_last) state_in = ST_CHECK;
         ST_CHECK:     state_in = stat.cut ? ST_DIV_INIT : ST_OUT_I;
         ST_DIV_INIT: begin
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) state_in = ST_GAIN;
         end
         ST_GAIN:      state_in = ST_OUT_I;
         ST_OUT_I:     state_in = ST_OUT_I2;
         ST_OUT_I2:    state_in = ST_OUT_Q2;
         ST_OUT_Q2:    state_in = ST_FINISH;
         ST_FINISH:    if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd = '0;
      cmd.mul_sel = MUL_XI_GAIN;
      case (state_ff)
         ST_IDLE:      cmd.req_load = req_valid;
         ST_MUL_I:     cmd.mul_sel = MUL_XI_GAIN;
         ST_SQ_I:      cmd.mul_sel = MUL_SQUARE;
         ST_MUL_Q: begin
            cmd.mul_sel  = MUL_XQ_GAIN;
            cmd.acc_load = 1'b1;
         end
         ST_SQ_Q:      cmd.mul_sel = MUL_SQUARE;
         ST_SUM:       cmd.acc_add = 1'b1;
         ST_ROOT_INIT: cmd.root_init = 1'b1;
         ST_ROOT:      cmd.root_step = 1'b1;
         ST_CHECK: begin
            cmd.mul_sel  = MUL_LIMIT_GAIN;
            cmd.cut_eval = 1'b1;
         end
         ST_DIV_INIT:  cmd.div_init = 1'b1;
         ST_DIV:       cmd.div_step = 1'b1;
         ST_GAIN:      cmd.gain_load = 1'b1;
         ST_OUT_I:     cmd.mul_sel = MUL_XI_GAIN;
         ST_OUT_I2: begin
            cmd.mul_sel    = MUL_XQ_GAIN;
            cmd.out_i_load = 1'b1;
         end
         ST_OUT_Q2:    cmd.out_q_load = 1'b1;
         ST_FINISH:    cmd.rsp_load = out_free;
         default:      cmd = '0;
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/isgpl_dp.sv =====
// Datapath: shared multiplier, bit-serial square root and divider, gain and output registers.
module isgpl_dp (
   input  logic                                          clock,
   input  logic                                          reset,
   input  isgpl_pkg::cmd_type                            cmd,
   output isgpl_pkg::status_type                         stat,
   input  isgpl_pkg::req_payload_type                    req_payload,
   output isgpl_pkg::rsp_payload_type                    rsp_payload,
   input  logic                                          csr_we,
   input  logic [isgpl_pkg::CSR_IDX_W-1:0]               csr_index,
   input  logic [isgpl_pkg::GAIN_W-1:0]                  csr_wdata
);
   import isgpl_pkg::*;

   // Scales a magnitude by 2047, drops 27 fraction bits and applies the sign with saturation.
   function automatic logic [15:0] scale_sat(input logic [31:0] p, input logic neg);
      logic [42:0] m;
      logic [15:0] t;
      logic [15:0] r;
      m = {p, 11'd0} - {11'd0, p};
      t = (m[42] != 1'b0) ? 16'hFFFF : m[42:27];
      if (neg) begin
         if (t > 16'd32768) r = 16'h8000;
         else r = ~t + 16'd1;
      end else begin
         if (t > 16'd32767) r = 16'h7FFF;
         else r = t;
      end
      return r;
   endfunction

   req_payload_type  item_ff;
   rsp_payload_type  rsp_ff;
   logic [15:0]      gain_ff, gain_in;
   logic [15:0]      limit_ff, limit_in;
   logic [63:0]      prod_ff, prod_in;
   logic [63:0]      acc_ff, acc_in;
   logic [33:0]      rem_ff, rem_in;
   logic [34:0]      root_ff, root_in;
   logic [34:0]      bitm_ff, bitm_in;
   logic [16:0]      drem_ff, drem_in;
   logic [15:0]      dvd_ff, dvd_in;
   logic             cut_ff;
   logic [15:0]      out_i_ff, out_q_ff;

   logic [16:0]      xi_abs, xq_abs, xi_ext, xq_ext;
   logic [31:0]      mul_a, mul_b;
   logic [34:0]      trial;
   logic [16:0]      mag;
   logic             cut;
   logic [17:0]      dshift;
   logic             dge;

   assign xi_ext = {item_ff.in_i[15], item_ff.in_i};
   assign xq_ext = {item_ff.in_q[15], item_ff.in_q};
   assign xi_abs = item_ff.in_i[15] ? (~xi_ext + 17'd1) : xi_ext;
   assign xq_abs = item_ff.in_q[15] ? (~xq_ext + 17'd1) : xq_ext;

   always_comb begin
      case (cmd.mul_sel)
         MUL_XI_GAIN: begin
            mul_a = {15'd0, xi_abs};
            mul_b = {16'd0, gain_ff};
         end
         MUL_XQ_GAIN: begin
            mul_a = {15'd0, xq_abs};
            mul_b = {16'd0, gain_ff};
         end
         MUL_SQUARE: begin
            mul_a = prod_ff[31:0];
            mul_b = prod_ff[31:0];
         end
         MUL_LIMIT_GAIN: begin
            mul_a = {16'd0, limit_ff};
            mul_b = {16'd0, gain_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   assign acc_in = cmd.acc_add ? (acc_ff + prod_ff) : prod_ff;

   // One root bit per cycle.
   assign trial = root_ff + bitm_ff;
   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff;
      bitm_in = bitm_ff;
      if (cmd.root_init) begin
         rem_in  = acc_ff[63:30];
         root_in = '0;
         bitm_in = 35'd1 << 32;
      end else if (cmd.root_step) begin
         bitm_in = bitm_ff >> 2;
         if ({1'b0, rem_ff} >= trial) begin
            rem_in  = 34'({1'b0, rem_ff} - trial);
            root_in = (root_ff >> 1) + bitm_ff;
         end else begin
            root_in = root_ff >> 1;
         end
      end
   end

   assign mag = root_ff[16:0];
   assign cut = (limit_ff != 16'd0) && (mag >= {1'b0, limit_ff});

   // One quotient bit per cycle; the quotient is known to fit 16 bits.
   assign dshift = {drem_ff, dvd_ff[15]};
   assign dge    = dshift >= {1'b0, mag};
   always_comb begin
      drem_in = drem_ff;
      dvd_in  = dvd_ff;
      if (cmd.div_init) begin
         drem_in = {1'b0, prod_ff[31:16]};
         dvd_in  = prod_ff[15:0];
      end else if (cmd.div_step) begin
         drem_in = dge ? 17'(dshift - {1'b0, mag}) : dshift[16:0];
         dvd_in  = {dvd_ff[14:0], dge};
      end
   end

   always_comb begin
      gain_in  = gain_ff;
      limit_in = limit_ff;
      if (csr_we && csr_index == REG_INITIAL_GAIN) gain_in = csr_wdata;
      else if (cmd.gain_load) gain_in = dvd_ff;
      if (csr_we && csr_index == REG_AGC_LIMIT) limit_in = csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= GAIN_RESET;
         limit_ff <= LIMIT_RESET;
      end else begin
         gain_ff  <= gain_in;
         limit_ff <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bitm_ff <= bitm_in;
      drem_ff <= drem_in;
      dvd_ff  <= dvd_in;
      if (cmd.req_load) item_ff <= req_payload;
      if (cmd.acc_load || cmd.acc_add) acc_ff <= acc_in;
      if (cmd.cut_eval) cut_ff <= cut;
      if (cmd.out_i_load) out_i_ff <= scale_sat(prod_ff[31:0], item_ff.in_i[15]);
      if (cmd.out_q_load) out_q_ff <= scale_sat(prod_ff[31:0], item_ff.in_q[15]);
      if (cmd.rsp_load) begin
         rsp_ff.out_i            <= out_i_ff;
         rsp_ff.out_q            <= out_q_ff;
         rsp_ff.gain_cut         <= cut_ff;
         rsp_ff.end_of_block_out <= item_ff.end_of_block;
      end
   end

   assign rsp_payload    = rsp_ff;
   assign stat.root_last = bitm_ff[0];
   assign stat.cut       = cut;
   assign stat.gain      = gain_ff;

endmodule

// ===== design/iq_soft_gain_peak_limiter_unit.sv =====
// Top level of the I/Q soft-gain peak limiter: controller, datapath and checks.
//
// Usage: each req_chan transaction carries one complex Q1.15 sample and an
// end-of-block marker. Both parts are scaled by the running Q4.12 gain, and
// the magnitude of the scaled sample is found with a bit-serial square root.
// When the limit is nonzero and the magnitude reaches it, the gain drops to
// limit*gain/magnitude through a restoring divider and the sample is scaled
// again. Each rsp_chan transaction returns the outputs scaled by 2047 and
// saturated, a gain-cut flag and the marker. One sample is processed at a
// time through a single shared multiplier; the next sample is accepted only
// once the result has been loaded into the output register. There it sits,
// so a stalled receiver holds rsp_chan steady; the block then completes the
// next sample and waits with it until the output register frees up.
// Synchronous reset sets the gain to 1.0 and the limit to zero (limiting
// off) and empties the pipeline. Writing initial_gain also reloads the
// running gain; the user must see that writes are made only while no
// transaction is in flight, as the block itself does not enforce this.
module iq_soft_gain_peak_limiter_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   isgpl_stream_if.sink                           req_chan,
   isgpl_stream_if.source                         rsp_chan,
   input  logic                                   csr_we,
   input  logic [isgpl_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [isgpl_pkg::GAIN_W-1:0]           csr_wdata
);
   import isgpl_pkg::*;

   cmd_type    cmd;
   status_type stat;

   // The controller sequences every step; the datapath holds all arithmetic.
   isgpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   isgpl_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_payload (req_chan.payload),
      .rsp_payload (rsp_chan.payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // The running gain only falls unless the initial gain register is written.
   a_gain_monotonic : assert property (@(posedge clock) disable iff (reset)
      !$past(csr_we) |-> stat.gain <= $past(stat.gain))
      else $error("running gain rose without a register write");

   // A new result is loaded only into a free output register.
   a_rsp_load_free : assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result overwrote a pending response");

   // After a sample is taken, no second sample is taken until it is done.
   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second transaction accepted while one is in flight");

endmodule

// ===== dv/iq_soft_gain_peak_limiter_unit_test.sv =====
// Self-checking testbench for the I/Q soft-gain peak limiter unit.
module iq_soft_gain_peak_limiter_unit_test;
   import isgpl_pkg::*;

   // A directed step is either one sample transaction or one register write.
   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      req_payload_type       sample;
      logic                  typed;
      rsp_payload_type       want;
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [GAIN_W-1:0]     reg_value;
   } plan_row_type;

   // How the receiver applies backpressure during one stretch of cycles.
   typedef enum int {RX_OPEN, RX_SPARSE, RX_BURSTY, RX_COIN} rx_mode_type;

   // Families of random samples: anything, near zero, corner codes, near full scale.
   typedef enum int {SHAPE_FULL, SHAPE_QUIET, SHAPE_CORNER, SHAPE_LOUD} shape_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [GAIN_W-1:0]     csr_wdata = '0;

   isgpl_stream_if #(.payload_type(req_payload_type)) req_chan ();
   isgpl_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   iq_soft_gain_peak_limiter_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Our own copy of the limiter state: the running gain and the limit register.
   logic [GAIN_W-1:0]  pred_gain = GAIN_RESET;
   logic [GAIN_W-1:0]  cfg_limit = LIMIT_RESET;

   // Outputs predicted for accepted samples, oldest first.
   rsp_payload_type    pending_outputs[$];
   int                 fault_count = 0;
   int                 outputs_seen = 0;

   // Sender pacing: valid is dropped for a random gap after each burst,
   // except while the sender is told to run steadily.
   logic               req_up = 1'b0;
   logic               steady_sender = 1'b0;
   int                 burst_left = 0;
   int                 gap_next = 0;

   plan_row_type       directed_plan[$];

   // Floor of the square root, built one result bit at a time from the top.
   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int b = 20; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   // Apply a Q4.12 gain and the 2047 DAC scale to a Q1.15 part. The product
   // is truncated toward zero, so negative parts are scaled as magnitudes.
   function automatic logic [15:0] dac_scale(input longint x, input logic [GAIN_W-1:0] g);
      longint      ax;
      logic [63:0] m;
      ax = (x < 0) ? -x : x;
      m = ax;
      m = (m * g * 64'd2047) >> 27;
      if (x < 0) begin
         if (m > 64'd32768) m = 64'd32768;
         m = -m;
         return m[15:0];
      end
      if (m > 64'd32767) m = 64'd32767;
      return m[15:0];
   endfunction

   // Predict one output transaction and advance the running gain. The
   // magnitude is taken on the sample scaled by the current gain; when it
   // reaches a nonzero limit, the gain shrinks in proportion and the output
   // is produced with the reduced gain.
   function automatic rsp_payload_type limit_and_scale(input req_payload_type s);
      rsp_payload_type r;
      longint          xi;
      longint          xq;
      logic [63:0]     pi;
      logic [63:0]     pq;
      logic [63:0]     power;
      logic [63:0]     root;
      logic [63:0]     quotient;
      xi = $signed(s.in_i);
      xq = $signed(s.in_q);
      pi = (xi < 0) ? -xi : xi;
      pq = (xq < 0) ? -xq : xq;
      pi = pi * pred_gain;
      pq = pq * pred_gain;
      power = pi * pi + pq * pq;
      root = floor_sqrt(power >> 30);
      r.gain_cut = 1'b0;
      if (cfg_limit != '0 && root >= cfg_limit) begin
         // The root is at least the limit, so the quotient never exceeds the gain.
         quotient = (64'(cfg_limit) * pred_gain) / root;
         pred_gain = quotient[GAIN_W-1:0];
         r.gain_cut = 1'b1;
      end
      r.out_i = dac_scale(xi, pred_gain);
      r.out_q = dac_scale(xq, pred_gain);
      r.end_of_block_out = s.end_of_block;
      return r;
   endfunction

   function automatic plan_row_type sample_row(input int i, input int q, input bit eob);
      plan_row_type r;
      r.kind = ROW_SAMPLE;
      r.sample.in_i = 16'(i);
      r.sample.in_q = 16'(q);
      r.sample.end_of_block = eob;
      r.typed = 1'b0;
      r.want = '0;
      r.reg_index = '0;
      r.reg_value = '0;
      return r;
   endfunction

   // A sample row whose output is written out by hand.
   function automatic plan_row_type checked_row(input int i, input int q, input bit eob,
                                                input int oi, input int oq, input bit cut);
      plan_row_type r;
      r = sample_row(i, q, eob);
      r.typed = 1'b1;
      r.want.out_i = 16'(oi);
      r.want.out_q = 16'(oq);
      r.want.gain_cut = cut;
      r.want.end_of_block_out = eob;
      return r;
   endfunction

   function automatic plan_row_type write_row(input logic [CSR_IDX_W-1:0] idx,
                                              input logic [GAIN_W-1:0] value);
      plan_row_type r;
      r = sample_row(0, 0, 1'b0);
      r.kind = ROW_WRITE;
      r.reg_index = idx;
      r.reg_value = value;
      return r;
   endfunction

   function automatic logic [15:0] corner_value();
      case ($urandom_range(0, 4))
         0: return 16'h8000;
         1: return 16'hFFFF;
         2: return 16'h0000;
         3: return 16'h0001;
         default: return 16'h7FFF;
      endcase
   endfunction

   // Half to full scale, either sign; the complement of the largest value
   // reaches down to the most negative code.
   function automatic logic [15:0] loud_value();
      logic [15:0] m;
      m = 16'($urandom_range(16384, 32767));
      return ($urandom_range(0, 1) != 0) ? ~m : m;
   endfunction

   // Offer one sample transaction, wait for the handshake, and queue what the
   // output must be. A hand-written output, when given, is queued instead of
   // the prediction, but the prediction still runs so the gain stays in step.
   task automatic send_sample(input req_payload_type s, input logic typed,
                              input rsp_payload_type typed_rsp);
      rsp_payload_type predicted;
      repeat (gap_next) @(posedge clock);
      gap_next = 0;
      req_chan.valid <= 1'b1;
      req_chan.payload <= s;
      req_up = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      predicted = limit_and_scale(s);
      pending_outputs.push_back(typed ? typed_rsp : predicted);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (!steady_sender) gap_next = $urandom_range(1, 12);
      end
      // Valid only drops when a gap follows; otherwise the next call keeps it high.
      if (gap_next > 0) begin
         req_chan.valid <= 1'b0;
         req_up = 1'b0;
      end
   endtask

   // Stop offering samples and wait until every queued output has been seen.
   // The queue is polled on the falling edge so the check cannot race the
   // output monitor at the rising edge.
   task automatic drain_results();
      if (req_up) begin
         req_chan.valid <= 1'b0;
         req_up = 1'b0;
      end
      while (pending_outputs.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // One register write; the enable is dropped again before the task returns,
   // so two writes in a row never touch the enable twice in one step.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_INITIAL_GAIN) pred_gain = value;
      else cfg_limit = value;
      @(posedge clock);
   endtask

   // Receiver backpressure. The mode is drawn anew after each span of random
   // length so that stalls land on every phase of the block's work, and open
   // stretches with no stalls at all come up as well.
   initial begin : receiver_stalls
      rx_mode_type mode;
      int          span;
      int          hold;
      logic        stalled;
      rsp_chan.ready = 1'b0;
      mode = RX_OPEN;
      span = 0;
      hold = 0;
      stalled = 1'b0;
      forever begin
         @(posedge clock);
         if (span == 0) begin
            mode = rx_mode_type'($urandom_range(0, 3));
            span = $urandom_range(50, 400);
         end
         span--;
         case (mode)
            RX_OPEN: rsp_chan.ready <= 1'b1;
            RX_SPARSE: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            RX_BURSTY: begin
               // Alternate runs of stalls with short open windows.
               if (hold == 0) begin
                  stalled = ~stalled;
                  hold = stalled ? $urandom_range(1, 12) : $urandom_range(1, 4);
               end
               hold--;
               rsp_chan.ready <= ~stalled;
            end
            default: rsp_chan.ready <= ($urandom_range(0, 1) != 0);
         endcase
      end
   end

   // Every output transaction is compared, field by field, with the oldest
   // prediction. Outputs arriving with nothing predicted are faults as well.
   always @(posedge clock) begin : output_check
      rsp_payload_type want;
      rsp_payload_type got;
      string           expected_text;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (pending_outputs.size() == 0) begin
            if (fault_count < 10)
               $display("unexpected output transaction: i=%0d q=%0d cut=%0b eob=%0b",
                        got.out_i, got.out_q, got.gain_cut, got.end_of_block_out);
            fault_count++;
         end else begin
            want = pending_outputs.pop_front();
            if (got.out_i !== want.out_i || got.out_q !== want.out_q ||
                got.gain_cut !== want.gain_cut ||
                got.end_of_block_out !== want.end_of_block_out) begin
               if (fault_count < 10) begin
                  expected_text = $sformatf("expected i=%0d q=%0d cut=%0b eob=%0b",
                                            want.out_i, want.out_q, want.gain_cut,
                                            want.end_of_block_out);
                  $display("output %0d: %s, got i=%0d q=%0d cut=%0b eob=%0b",
                           outputs_seen, expected_text, got.out_i, got.out_q,
                           got.gain_cut, got.end_of_block_out);
               end
               fault_count++;
            end
            outputs_seen++;
         end
      end
   end

   // Stimulus: a directed walk through the corner cases, then random phases,
   // each with its own limit setting and, in most phases, a fresh gain.
   initial begin : stimulus
      req_payload_type s;
      shape_type       shape;
      logic [15:0]     gain_pick;
      logic [15:0]     limit_pick;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;

      // Reset values: unity gain, limiting off. Full-scale parts come out at
      // just under 2047 on the positive side and exactly 2047 on the negative.
      directed_plan.push_back(checked_row(0, 0, 1'b0, 0, 0, 1'b0));
      directed_plan.push_back(checked_row(32767, 32767, 1'b1, 2046, 2046, 1'b0));
      directed_plan.push_back(checked_row(-32768, -32768, 1'b0, -2047, -2047, 1'b0));
      // The smallest negative part truncates toward zero, not to -1.
      directed_plan.push_back(checked_row(-1, 1, 1'b1, 0, 0, 1'b0));
      // Largest gain with limiting off: the output gets close to full scale.
      directed_plan.push_back(write_row(REG_INITIAL_GAIN, 16'hFFFF));
      directed_plan.push_back(sample_row(32767, -32768, 1'b0));
      directed_plan.push_back(sample_row(-32768, 32767, 1'b1));
      // A half-scale sample at unity gain has magnitude 0.5, equal to the limit:
      // the cut flag fires but the gain does not move.
      directed_plan.push_back(write_row(REG_INITIAL_GAIN, GAIN_RESET));
      directed_plan.push_back(write_row(REG_AGC_LIMIT, 16'd2048));
      directed_plan.push_back(checked_row(16384, 0, 1'b0, 1023, 0, 1'b1));
      directed_plan.push_back(checked_row(0, 16384, 1'b1, 0, 1023, 1'b1));
      // Limit 0.25 halves the gain on the next half-scale sample; after that the
      // negated sample sits right at the limit and a small one is left alone.
      directed_plan.push_back(write_row(REG_AGC_LIMIT, 16'd1024));
      directed_plan.push_back(checked_row(16384, 0, 1'b0, 511, 0, 1'b1));
      directed_plan.push_back(checked_row(-16384, 0, 1'b0, -511, 0, 1'b1));
      directed_plan.push_back(checked_row(4096, 0, 1'b1, 127, 0, 1'b0));
      // Zero gain gives zero magnitude, so even the smallest limit never fires.
      directed_plan.push_back(write_row(REG_INITIAL_GAIN, 16'd0));
      directed_plan.push_back(write_row(REG_AGC_LIMIT, 16'd1));
      directed_plan.push_back(checked_row(32767, -32768, 1'b1, 0, 0, 1'b0));
      // Both registers at their maximum: the first full-scale sample still exceeds the limit.
      directed_plan.push_back(write_row(REG_INITIAL_GAIN, 16'hFFFF));
      directed_plan.push_back(write_row(REG_AGC_LIMIT, 16'hFFFF));
      directed_plan.push_back(sample_row(-32768, -32768, 1'b0));
      directed_plan.push_back(sample_row(32767, 32767, 1'b1));
      directed_plan.push_back(sample_row(12345, -23456, 1'b0));
      directed_plan.push_back(write_row(REG_AGC_LIMIT, LIMIT_RESET));
      directed_plan.push_back(sample_row(-32768, 32767, 1'b1));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[k]) begin
         if (directed_plan[k].kind == ROW_WRITE) begin
            drain_results();
            write_csr(directed_plan[k].reg_index, directed_plan[k].reg_value);
         end else begin
            send_sample(directed_plan[k].sample, directed_plan[k].typed, directed_plan[k].want);
         end
      end

      for (int phase = 0; phase < 12; phase++) begin
         drain_results();
         case ($urandom_range(0, 7))
            0: gain_pick = 16'd0;
            1: gain_pick = 16'hFFFF;
            2: gain_pick = GAIN_RESET;
            3, 4, 5: gain_pick = 16'($urandom_range(2048, 16384));
            default: gain_pick = 16'($urandom);
         endcase
         case ($urandom_range(0, 7))
            0: limit_pick = LIMIT_RESET;
            1: limit_pick = 16'hFFFF;
            2: limit_pick = 16'd1;
            default: limit_pick = 16'($urandom_range(512, 12288));
         endcase
         // Now and then the gain is left where the last phase brought it down.
         if (phase < 2 || $urandom_range(0, 3) != 0) write_csr(REG_INITIAL_GAIN, gain_pick);
         write_csr(REG_AGC_LIMIT, limit_pick);
         steady_sender = ($urandom_range(0, 3) == 0);

         for (int n = 0; n < 112; n++) begin
            // Midway, let the block run dry and restore a high gain so the
            // limiter has to pull it down again.
            if (n == 56) begin
               drain_results();
               write_csr(REG_INITIAL_GAIN, 16'($urandom_range(4096, 65535)));
            end
            shape = shape_type'($urandom_range(0, 3));
            case (shape)
               SHAPE_FULL: begin
                  s.in_i = 16'($urandom);
                  s.in_q = 16'($urandom);
               end
               SHAPE_QUIET: begin
                  s.in_i = 16'($urandom_range(0, 2047)) - 16'd1024;
                  s.in_q = 16'($urandom_range(0, 2047)) - 16'd1024;
               end
               SHAPE_CORNER: begin
                  s.in_i = corner_value();
                  s.in_q = corner_value();
               end
               default: begin
                  s.in_i = loud_value();
                  s.in_q = loud_value();
               end
            endcase
            s.end_of_block = ($urandom_range(0, 7) == 0);
            send_sample(s, 1'b0, '0);
         end
      end

      drain_results();
      // Room for a stray output.
      repeat (60) @(posedge clock);
      if (fault_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Several times the slowest correct run: every sample cut, long receiver
   // stalls and the longest sender gaps.
   initial begin : watchdog
      #5000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
